// File: rtl/core/apt_pkg.sv
// Shared types, widths and register codes for the affine point transform.
// Used by apt_row and affine_point_transform; depends on nothing else.
package apt_pkg;

  // Field widths of points, coefficients and the datapath.
  localparam int COORD_W    = 20;
  localparam int COEF_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = COEF_W + DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int ROT_W      = ACC_W - FRAC_SHIFT;
  localparam int SUM_W      = ROT_W + 2;
  localparam int NUM_AXES   = 3;

  // Configuration port widths.
  localparam int ROW_W      = NUM_AXES * COEF_W;
  localparam int CENTER_W   = NUM_AXES * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CENTER_W;

  // Register reset values: identity matrix, zero offsets.
  localparam logic [ROW_W-1:0] ROW0_RESET = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 48'h4000_0000_0000;

  // Largest and smallest coordinate values for saturation.
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Round-to-nearest bias, half of one output LSB in Q.14.
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0       = 3'd0,
    REG_ROW1       = 3'd1,
    REG_ROW2       = 3'd2,
    REG_CENTER_OLD = 3'd3,
    REG_CENTER_BASE= 3'd4,
    REG_TRANSLATION= 3'd5,
    REG_ENABLE     = 3'd6
  } cfg_reg_t;

  // Control that travels down the pipeline with each point.
  typedef struct packed {
    logic valid;
    logic last;
    logic en;
  } stage_ctl_t;

endpackage

// File: rtl/core/affine_point_transform.sv
// Top level of the affine point transform: configuration registers and pipeline control.
// Depends on apt_pkg and apt_row.
//
// Usage:
//   Points enter on x_in, y_in, z_in and last_point; a transfer happens at a clock
//   edge where start is high and busy is low. busy is always low, so a new point
//   may enter every cycle.
//   Each result appears on x_out, y_out, z_out, last_point_out and transformed for
//   exactly one cycle, marked by done.
//   Throughput is one point per cycle; the datapath has four register stages:
//   center subtract, coefficient multiply, rounded row sum, and offset add with
//   saturation.
//   The receiver cannot stall; results leave in input order and never wait.
//   Configuration registers are written through cfg_valid/cfg_ready with a
//   register index and data; cfg_ready is always high. Write them only while no
//   point is in flight. Unknown indexes are ignored.
//   Reset (synchronous, active high) restores the identity matrix, zero centers
//   and translation, disables the transform, and empties the pipeline.
module affine_point_transform (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  apt_pkg::coord_t                  x_in,
  input  apt_pkg::coord_t                  y_in,
  input  apt_pkg::coord_t                  z_in,
  input  logic                             last_point,
  output logic                             done,
  output apt_pkg::coord_t                  x_out,
  output apt_pkg::coord_t                  y_out,
  output apt_pkg::coord_t                  z_out,
  output logic                             last_point_out,
  output logic                             transformed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [apt_pkg::ROW_W-1:0]    row_coefs [apt_pkg::NUM_AXES];
  logic [apt_pkg::CENTER_W-1:0] center_old;
  logic [apt_pkg::CENTER_W-1:0] center_base;
  logic [apt_pkg::CENTER_W-1:0] translation;
  logic                         transform_enable;

  logic                 accept;
  apt_pkg::coord_t      p_in [apt_pkg::NUM_AXES];
  apt_pkg::coord_t      p_s1 [apt_pkg::NUM_AXES];
  apt_pkg::coord_t      p_s2 [apt_pkg::NUM_AXES];
  apt_pkg::coord_t      p_s3 [apt_pkg::NUM_AXES];
  apt_pkg::diff_t       d_s1 [apt_pkg::NUM_AXES];
  apt_pkg::coord_t      row_out [apt_pkg::NUM_AXES];
  apt_pkg::stage_ctl_t  ctl_s1;
  apt_pkg::stage_ctl_t  ctl_s2;
  apt_pkg::stage_ctl_t  ctl_s3;
  apt_pkg::stage_ctl_t  ctl_s4;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign p_in[0] = x_in;
  assign p_in[1] = y_in;
  assign p_in[2] = z_in;

  // Configuration registers; bits above each register's width are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_coefs[0]     <= apt_pkg::ROW0_RESET;
      row_coefs[1]     <= apt_pkg::ROW1_RESET;
      row_coefs[2]     <= apt_pkg::ROW2_RESET;
      center_old       <= '0;
      center_base      <= '0;
      translation      <= '0;
      transform_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (apt_pkg::cfg_reg_t'(cfg_index))
        apt_pkg::REG_ROW0:        row_coefs[0]     <= cfg_data[apt_pkg::ROW_W-1:0];
        apt_pkg::REG_ROW1:        row_coefs[1]     <= cfg_data[apt_pkg::ROW_W-1:0];
        apt_pkg::REG_ROW2:        row_coefs[2]     <= cfg_data[apt_pkg::ROW_W-1:0];
        apt_pkg::REG_CENTER_OLD:  center_old       <= cfg_data;
        apt_pkg::REG_CENTER_BASE: center_base      <= cfg_data;
        apt_pkg::REG_TRANSLATION: translation      <= cfg_data;
        apt_pkg::REG_ENABLE:      transform_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: valid, last-point marker and enable travel with each point.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
      ctl_s2 <= '0;
      ctl_s3 <= '0;
      ctl_s4 <= '0;
    end else begin
      ctl_s1 <= '{valid: accept, last: last_point, en: transform_enable};
      ctl_s2 <= ctl_s1;
      ctl_s3 <= ctl_s2;
      ctl_s4 <= ctl_s3;
    end
  end

  // Stage 1: subtract the old center; keep the raw point for pass-through.
  always_ff @(posedge clk) begin
    for (int c = 0; c < apt_pkg::NUM_AXES; c++) begin
      d_s1[c] <= apt_pkg::DIFF_W'(p_in[c])
               - apt_pkg::DIFF_W'(apt_pkg::coord_t'(
                   center_old[c*apt_pkg::COORD_W +: apt_pkg::COORD_W]));
      p_s1[c] <= p_in[c];
      p_s2[c] <= p_s1[c];
      p_s3[c] <= p_s2[c];
    end
  end

  // Stages 2 to 4: one matrix row per output coordinate.
  for (genvar r = 0; r < apt_pkg::NUM_AXES; r++) begin : g_row
    apt_row u_row (
      .clk       (clk),
      .d         (d_s1),
      .coefs     (row_coefs[r]),
      .base      (apt_pkg::coord_t'(center_base[r*apt_pkg::COORD_W +: apt_pkg::COORD_W])),
      .trans     (apt_pkg::coord_t'(translation[r*apt_pkg::COORD_W +: apt_pkg::COORD_W])),
      .bypass_s3 (p_s3[r]),
      .ctl_s3    (ctl_s3),
      .result    (row_out[r])
    );
  end

  // Result ports.
  assign done           = ctl_s4.valid;
  assign last_point_out = ctl_s4.last;
  assign transformed    = ctl_s4.en;
  assign x_out          = row_out[0];
  assign y_out          = row_out[1];
  assign z_out          = row_out[2];

`ifndef SYNTH
  // Every result matches an earlier input transfer.
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without a matching input transfer");

  // Every accepted point produces a result.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("input transfer lost in the pipeline");

  // The last-point marker stays aligned with its point.
  a_last_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> last_point_out == $past(last_point, 4))
    else $error("last-point marker out of step");

  // A pass-through point leaves unchanged.
  a_bypass_exact: assert property (@(posedge clk) disable iff (rst)
    (done && !transformed) |->
      (x_out == $past(x_in, 4) && y_out == $past(y_in, 4) && z_out == $past(z_in, 4)))
    else $error("pass-through point altered");
`endif

endmodule

// File: rtl/core/apt_row.sv
// One output row of the transform: products, rounded sum, offset and saturation.
// Depends on apt_pkg; instantiated three times by affine_point_transform.
module apt_row (
  input  logic                        clk,
  input  apt_pkg::diff_t              d [apt_pkg::NUM_AXES],
  input  logic [apt_pkg::ROW_W-1:0]   coefs,
  input  apt_pkg::coord_t             base,
  input  apt_pkg::coord_t             trans,
  input  apt_pkg::coord_t             bypass_s3,
  input  apt_pkg::stage_ctl_t         ctl_s3,
  output apt_pkg::coord_t             result
);

  logic signed [apt_pkg::PROD_W-1:0] coef_ext [apt_pkg::NUM_AXES];
  logic signed [apt_pkg::PROD_W-1:0] d_ext    [apt_pkg::NUM_AXES];
  logic signed [apt_pkg::PROD_W-1:0] prod     [apt_pkg::NUM_AXES];
  logic signed [apt_pkg::ACC_W-1:0]  acc;
  logic signed [apt_pkg::ROT_W-1:0]  rot;
  logic signed [apt_pkg::SUM_W-1:0]  sum;
  apt_pkg::coord_t                   sat;

  // Sign-extend coefficients and differences to the product width.
  always_comb begin
    for (int c = 0; c < apt_pkg::NUM_AXES; c++) begin
      coef_ext[c] = apt_pkg::PROD_W'(apt_pkg::coef_t'(coefs[c*apt_pkg::COEF_W +: apt_pkg::COEF_W]));
      d_ext[c]    = apt_pkg::PROD_W'(d[c]);
    end
  end

  // Stage 2: the three coefficient products.
  always_ff @(posedge clk) begin
    for (int c = 0; c < apt_pkg::NUM_AXES; c++) begin
      prod[c] <= coef_ext[c] * d_ext[c];
    end
  end

  // Stage 3: sum with rounding bias, then drop the fraction bits.
  always_comb begin
    acc = apt_pkg::ACC_W'(prod[0]) + apt_pkg::ACC_W'(prod[1])
        + apt_pkg::ACC_W'(prod[2]) + apt_pkg::ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    rot <= acc[apt_pkg::ACC_W-1:apt_pkg::FRAC_SHIFT];
  end

  // Stage 4: add base center and translation, clamp to the coordinate range.
  always_comb begin
    sum = apt_pkg::SUM_W'(rot) + apt_pkg::SUM_W'(base) + apt_pkg::SUM_W'(trans);
    if (sum > apt_pkg::SUM_W'(apt_pkg::COORD_MAX)) begin
      sat = apt_pkg::COORD_MAX;
    end else if (sum < apt_pkg::SUM_W'(apt_pkg::COORD_MIN)) begin
      sat = apt_pkg::COORD_MIN;
    end else begin
      sat = sum[apt_pkg::COORD_W-1:0];
    end
  end

  // Disabled points leave unchanged.
  always_ff @(posedge clk) begin
    result <= ctl_s3.en ? sat : bypass_s3;
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for affine_point_transform: directed and random points
// checked against an in-bench transform of each point.  Depends on apt_pkg and the RTL.
module tb_top;
  import apt_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ROUNDS      = 10;
  localparam int ROUND_LEN   = 50;
  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One transformed point as the block should present it.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   xf;
  } aligned_pt_t;

  // Mirrors the register file, transforms each accepted point and checks results
  // in order against the queue of transformed points.
  class transform_tracker;
    logic [ROW_W-1:0]    rows [NUM_AXES];
    logic [CENTER_W-1:0] old_ctr;
    logic [CENTER_W-1:0] base_ctr;
    logic [CENTER_W-1:0] offset;
    logic                en;
    aligned_pt_t         aligned_q [$];
    int                  errors;
    int                  n_results;
    int                  n_xf;

    function new();
      rows[0]   = ROW0_RESET;
      rows[1]   = ROW1_RESET;
      rows[2]   = ROW2_RESET;
      old_ctr   = '0;
      base_ctr  = '0;
      offset    = '0;
      en        = 1'b0;
      errors    = 0;
      n_results = 0;
      n_xf      = 0;
    endfunction

    // Register write as the block sees it; bits above a register's width drop off.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROW0:        rows[0]  = data[ROW_W-1:0];
        REG_ROW1:        rows[1]  = data[ROW_W-1:0];
        REG_ROW2:        rows[2]  = data[ROW_W-1:0];
        REG_CENTER_OLD:  old_ctr  = data[CENTER_W-1:0];
        REG_CENTER_BASE: base_ctr = data[CENTER_W-1:0];
        REG_TRANSLATION: offset   = data[CENTER_W-1:0];
        REG_ENABLE:      en       = data[0];
        default: ;
      endcase
    endfunction

    // Subtract the old center, rotate, round to nearest with ties upward, add the
    // base center and translation, then clamp to the coordinate range.
    function aligned_pt_t align_point(coord_t px, coord_t py, coord_t pz, logic last);
      longint      p [NUM_AXES];
      longint      d [NUM_AXES];
      longint      acc;
      longint      sum;
      coord_t      res [NUM_AXES];
      aligned_pt_t r;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      if (en) begin
        for (int c = 0; c < NUM_AXES; c++)
          d[c] = p[c] - longint'($signed(old_ctr[c*COORD_W +: COORD_W]));
        for (int k = 0; k < NUM_AXES; k++) begin
          acc = 0;
          for (int c = 0; c < NUM_AXES; c++)
            acc += longint'($signed(rows[k][c*COEF_W +: COEF_W])) * d[c];
          sum = ((acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT)
                + longint'($signed(base_ctr[k*COORD_W +: COORD_W]))
                + longint'($signed(offset[k*COORD_W +: COORD_W]));
          if (sum > longint'(COORD_MAX))
            res[k] = COORD_MAX;
          else if (sum < longint'(COORD_MIN))
            res[k] = COORD_MIN;
          else
            res[k] = coord_t'(sum);
        end
      end else begin
        for (int c = 0; c < NUM_AXES; c++)
          res[c] = coord_t'(p[c]);
      end
      r.x    = res[0];
      r.y    = res[1];
      r.z    = res[2];
      r.last = last;
      r.xf   = en;
      return r;
    endfunction

    function void note_point(coord_t px, coord_t py, coord_t pz, logic last);
      aligned_q.push_back(align_point(px, py, pz, last));
    endfunction

    function int outstanding();
      return aligned_q.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10)
        $display("ERROR: %s", msg);
    endfunction

    // Compare one result transfer with the oldest transformed point.
    function void check_point(coord_t x, coord_t y, coord_t z, logic last, logic xf);
      aligned_pt_t want;
      n_results++;
      if (xf === 1'b1)
        n_xf++;
      if (aligned_q.size() == 0) begin
        flag_error($sformatf("result with no point in flight: x=%0d y=%0d z=%0d last=%b xf=%b",
                             x, y, z, last, xf));
        return;
      end
      want = aligned_q.pop_front();
      if (x !== want.x || y !== want.y || z !== want.z ||
          last !== want.last || xf !== want.xf)
        flag_error($sformatf({"result %0d: got x=%0d y=%0d z=%0d last=%b xf=%b, ",
                              "want x=%0d y=%0d z=%0d last=%b xf=%b"},
                             n_results, x, y, z, last, xf,
                             want.x, want.y, want.z, want.last, want.xf));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  coord_t                x_in = '0;
  coord_t                y_in = '0;
  coord_t                z_in = '0;
  logic                  last_point = 1'b0;
  logic                  done;
  coord_t                x_out;
  coord_t                y_out;
  coord_t                z_out;
  logic                  last_point_out;
  logic                  transformed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  transform_tracker sb;
  bit no_gaps    = 1'b0;
  int cycles     = 0;
  int n_sent     = 0;
  int n_writes   = 0;
  int n_settings = 0;

  affine_point_transform dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .x_in           (x_in),
    .y_in           (y_in),
    .z_in           (z_in),
    .last_point     (last_point),
    .done           (done),
    .x_out          (x_out),
    .y_out          (y_out),
    .z_out          (z_out),
    .last_point_out (last_point_out),
    .transformed    (transformed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Every cycle with done high is one result transfer.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_point(x_out, y_out, z_out, last_point_out, transformed);
  end

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  // mode 0: any value, 1: near zero, 2: range ends and neighbours of zero.
  function automatic coord_t rand_coord(int mode);
    if (mode == 2) begin
      case ($urandom_range(0, 4))
        0:       return COORD_MAX;
        1:       return COORD_MIN;
        2:       return '0;
        3:       return -20'sd1;
        default: return 20'sd1;
      endcase
    end
    if (mode == 1)
      return coord_t'(int'($urandom_range(0, 4095)) - 2048);
    return coord_t'($urandom);
  endfunction

  function automatic int point_mode();
    int r;
    r = $urandom_range(0, 19);
    return (r < 8) ? 0 : (r < 17) ? 1 : 2;
  endfunction

  function automatic logic [CENTER_W-1:0] pack_coords(coord_t a, coord_t b, coord_t c);
    return {c, b, a};
  endfunction

  function automatic logic [ROW_W-1:0] pack_coefs(coef_t a, coef_t b, coef_t c);
    return {c, b, a};
  endfunction

  // A matrix row with junk above bit 47, which the block must drop.
  function automatic logic [CFG_DATA_W-1:0] rand_row(bit extreme);
    logic [CFG_DATA_W-1:0] data;
    coef_t                 k;
    data = rand_word();
    for (int c = 0; c < NUM_AXES; c++) begin
      if (extreme) begin
        case ($urandom_range(0, 5))
          0:       k = 16'sh7FFF;
          1:       k = 16'sh8000;
          2:       k = '0;
          3:       k = 16'sh4000;
          4:       k = 16'shC000;
          default: k = 16'sh2000;
        endcase
      end else if ($urandom_range(0, 1) == 1) begin
        k = coef_t'(int'($urandom_range(0, 32768)) - 16384);
      end else begin
        k = coef_t'($urandom);
      end
      data[c*COEF_W +: COEF_W] = k;
    end
    return data;
  endfunction

  function automatic logic [CENTER_W-1:0] rand_center(bit extreme);
    logic [CENTER_W-1:0] data;
    for (int c = 0; c < NUM_AXES; c++)
      data[c*COORD_W +: COORD_W] = rand_coord(extreme ? 2 : ($urandom_range(0, 4) == 0) ? 0 : 1);
    return data;
  endfunction

  // One point transfer after a random gap; start stays high across back-to-back points.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                            input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    x_in       <= px;
    y_in       <= py;
    z_in       <= pz;
    last_point <= last;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_point(px, py, pz, last);
    n_sent++;
  endtask

  // Hold off new points until every transformed point has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // One register write transfer; the caller lowers cfg_valid after the last one.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  // Load a full setting while the block is idle, optionally poking the unused index.
  task automatic load_setting(input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                              input logic [CFG_DATA_W-1:0] r2, input logic [CFG_DATA_W-1:0] c_old,
                              input logic [CFG_DATA_W-1:0] c_base,
                              input logic [CFG_DATA_W-1:0] shift,
                              input logic [CFG_DATA_W-1:0] en, input bit poke_unused);
    wait_idle();
    write_cfg(REG_ROW0, r0);
    write_cfg(REG_ROW1, r1);
    write_cfg(REG_ROW2, r2);
    write_cfg(REG_CENTER_OLD, c_old);
    if (poke_unused)
      write_cfg(REG_UNUSED, rand_word());
    write_cfg(REG_CENTER_BASE, c_base);
    write_cfg(REG_TRANSLATION, shift);
    write_cfg(REG_ENABLE, en);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] en_word;
    bit                    extreme;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state passes points straight through.
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point('0, -20'sd1, 20'sd1, 1'b0);

    // The reset matrix is the identity; a write to the unused index changes nothing.
    wait_idle();
    write_cfg(REG_UNUSED, '1);
    write_cfg(REG_ENABLE, 60'd1);
    cfg_valid <= 1'b0;
    n_settings++;
    send_point(COORD_MAX, COORD_MIN, 20'sd1, 1'b1);
    send_point(COORD_MIN, COORD_MAX, -20'sd1, 1'b0);

    // Largest coefficients, junk above the row width: clamps at the top.
    load_setting({12'hFFF, pack_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF)},
                 {12'hFFF, pack_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF)},
                 {12'hFFF, pack_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF)},
                 pack_coords(COORD_MIN, COORD_MIN, COORD_MIN),
                 pack_coords(COORD_MAX, COORD_MAX, COORD_MAX),
                 pack_coords(COORD_MAX, COORD_MAX, COORD_MAX), 60'd1, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

    // Most negative coefficients and offsets: clamps at the bottom, and at the top.
    load_setting(pack_coefs(16'sh8000, 16'sh8000, 16'sh8000),
                 pack_coefs(16'sh8000, 16'sh8000, 16'sh8000),
                 pack_coefs(16'sh8000, 16'sh8000, 16'sh8000), '0,
                 pack_coords(COORD_MIN, COORD_MIN, COORD_MIN),
                 pack_coords(COORD_MIN, COORD_MIN, COORD_MIN), 60'd1, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point('0, '0, '0, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

    // Half-LSB products: exact ties round upward for both signs.
    load_setting(pack_coefs(16'sh2000, '0, '0), pack_coefs(16'shE000, '0, '0),
                 pack_coefs(16'sh0001, '0, '0), '0, '0, '0, 60'd1, 1'b0);
    send_point(20'sd1, '0, '0, 1'b0);
    send_point(-20'sd1, '0, '0, 1'b0);
    send_point(20'sd3, '0, '0, 1'b0);
    send_point(-20'sd3, '0, '0, 1'b1);

    // Disabled with a non-identity setting loaded: still a plain pass-through.
    wait_idle();
    write_cfg(REG_ENABLE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
    cfg_valid <= 1'b0;
    n_settings++;
    send_point(20'sd12345, -20'sd54321, COORD_MAX, 1'b1);
    send_point(COORD_MIN, '0, 20'sd77, 1'b0);

    // Random rounds, each under a fresh setting; some rounds run without gaps.
    for (int k = 0; k < ROUNDS; k++) begin
      extreme = (k % 4 == 0);
      en_word = rand_word();
      en_word[0] = ($urandom_range(0, 3) != 0);
      load_setting(rand_row(extreme), rand_row(extreme), rand_row(extreme),
                   rand_center(extreme), rand_center(extreme), rand_center(extreme),
                   en_word, $urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ROUND_LEN; n++) begin
        if (k == 3 && n == ROUND_LEN / 2)
          wait_idle();
        send_point(rand_coord(point_mode()), rand_coord(point_mode()),
                   rand_coord(point_mode()), $urandom_range(0, 7) == 0);
      end
    end

    // Drain, then give a stray late result time to show up.
    wait_idle();
    repeat (8) @(posedge clk);

    $display("summary: %0d points, %0d results (%0d transformed), %0d writes in %0d settings",
             n_sent, sb.n_results, sb.n_xf, n_writes, n_settings);
    $display("summary: %0d errors, %0d results still owed", sb.errors, sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// File: files.f
rtl/core/apt_pkg.sv
rtl/core/apt_row.sv
rtl/core/affine_point_transform.sv
sim/tb_top.sv
